// ----- sv/dual_updown_counter_seven_seg_scan_core_defines.svh -----
// Assertion macros for the dual up/down counter scan core.
// Included by the top level; expects clk and rst_n in scope.
`ifndef DUAL_UPDOWN_COUNTER_SEVEN_SEG_SCAN_CORE_DEFINES_SVH
`define DUAL_UPDOWN_COUNTER_SEVEN_SEG_SCAN_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define DUSC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset
`define DUSC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/dusc_pkg.sv -----
// Shared types, constants and helper functions of the dual counter scan core.
// No dependencies; imported by every module of the block.
`default_nettype none

package dusc_pkg;

  // Counter range
  localparam int COUNT_MODULUS = 1000;
  localparam int CNT_W         = 10;
  localparam int DIG_W         = 4;

  // Counter value with its decimal digits kept alongside
  typedef struct packed {
    logic [CNT_W-1:0] bin;
    logic [DIG_W-1:0] hun;
    logic [DIG_W-1:0] ten;
    logic [DIG_W-1:0] uni;
  } cnt_t;

  localparam int RST_A   = 984 % COUNT_MODULUS;
  localparam int TOP_VAL = COUNT_MODULUS - 1;

  localparam cnt_t CNT_ZERO = '0;
  localparam cnt_t CNT_RST_A = '{
    bin: CNT_W'(RST_A),
    hun: DIG_W'(RST_A / 100),
    ten: DIG_W'((RST_A / 10) % 10),
    uni: DIG_W'(RST_A % 10)
  };
  localparam cnt_t CNT_TOP = '{
    bin: CNT_W'(TOP_VAL),
    hun: DIG_W'(TOP_VAL / 100),
    ten: DIG_W'((TOP_VAL / 10) % 10),
    uni: DIG_W'(TOP_VAL % 10)
  };

  // Button bit positions
  localparam int BTN_UP_A = 0;
  localparam int BTN_DN_A = 1;
  localparam int BTN_UP_B = 2;
  localparam int BTN_DN_B = 3;

  // Scan positions
  localparam logic [2:0] POS_A_HUN = 3'd0;
  localparam logic [2:0] POS_A_TEN = 3'd1;
  localparam logic [2:0] POS_A_UNI = 3'd2;
  localparam logic [2:0] POS_SEP_0 = 3'd3;
  localparam logic [2:0] POS_SEP_1 = 3'd4;
  localparam logic [2:0] POS_B_HUN = 3'd5;
  localparam logic [2:0] POS_B_TEN = 3'd6;
  localparam logic [2:0] POS_B_UNI = 3'd7;

  localparam logic [7:0] SEP_PATTERN = 8'h08;
  localparam logic [7:0] DWELL_RST   = 8'd5;

  // Counter pair handed from the counter stage to the scan stage
  typedef struct packed {
    cnt_t a;
    cnt_t b;
  } cnt_pair_t;

  // Step up with wrap, carrying through the decimal digits
  function automatic cnt_t cnt_up(cnt_t c);
    cnt_t r;
    r = c;
    if (c.bin >= CNT_W'(TOP_VAL)) begin
      r = CNT_ZERO;
    end else begin
      r.bin = c.bin + CNT_W'(1);
      if (c.uni == DIG_W'(9)) begin
        r.uni = '0;
        if (c.ten == DIG_W'(9)) begin
          r.ten = '0;
          r.hun = c.hun + DIG_W'(1);
        end else begin
          r.ten = c.ten + DIG_W'(1);
        end
      end else begin
        r.uni = c.uni + DIG_W'(1);
      end
    end
    return r;
  endfunction

  // Step down with wrap, borrowing through the decimal digits
  function automatic cnt_t cnt_down(cnt_t c);
    cnt_t r;
    r = c;
    if (c.bin == '0 || c.bin >= CNT_W'(COUNT_MODULUS)) begin
      r = CNT_TOP;
    end else begin
      r.bin = c.bin - CNT_W'(1);
      if (c.uni == '0) begin
        r.uni = DIG_W'(9);
        if (c.ten == '0) begin
          r.ten = DIG_W'(9);
          r.hun = c.hun - DIG_W'(1);
        end else begin
          r.ten = c.ten - DIG_W'(1);
        end
      end else begin
        r.uni = c.uni - DIG_W'(1);
      end
    end
    return r;
  endfunction

  // Seven-segment pattern, active high, bits gfedcba
  function automatic logic [7:0] seg_of(logic [DIG_W-1:0] d);
    logic [7:0] p;
    case (d)
      4'd0:    p = 8'h3F;
      4'd1:    p = 8'h06;
      4'd2:    p = 8'h5B;
      4'd3:    p = 8'h4F;
      4'd4:    p = 8'h66;
      4'd5:    p = 8'h6D;
      4'd6:    p = 8'h7D;
      4'd7:    p = 8'h07;
      4'd8:    p = 8'h7F;
      4'd9:    p = 8'h6F;
      default: p = 8'h00;
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

// ----- sv/dusc_counters.sv -----
// Release detection and the two wrapping up/down counters.
// Depends on dusc_pkg.
`default_nettype none

module dusc_counters
  import dusc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       step,
  input  wire logic [3:0] buttons,
  output cnt_pair_t       cnt_nxt
);

  logic [3:0] last_btn_r;
  cnt_t       cnt_a_r;
  cnt_t       cnt_b_r;
  logic [3:0] released;
  cnt_t       a_up;
  cnt_t       a_dn;
  cnt_t       b_up;
  cnt_t       b_dn;

  // Act on falling edges, in the order upA, downA, upB, downB
  always_comb begin
    released = last_btn_r & ~buttons;
    a_up = released[BTN_UP_A] ? cnt_up(cnt_a_r) : cnt_a_r;
    a_dn = released[BTN_DN_A] ? cnt_down(a_up) : a_up;
    b_up = released[BTN_UP_B] ? cnt_up(cnt_b_r) : cnt_b_r;
    b_dn = released[BTN_DN_B] ? cnt_down(b_up) : b_up;
    cnt_nxt.a = a_dn;
    cnt_nxt.b = b_dn;
  end

  // Commit counters and button levels per beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_btn_r <= '0;
      cnt_a_r    <= CNT_RST_A;
      cnt_b_r    <= CNT_ZERO;
    end else if (step) begin
      last_btn_r <= buttons;
      cnt_a_r    <= cnt_nxt.a;
      cnt_b_r    <= cnt_nxt.b;
    end
  end

endmodule

`default_nettype wire

// ----- sv/dusc_scan.sv -----
// Digit scan: dwell counting, scan position and segment selection.
// Depends on dusc_pkg.
`default_nettype none

module dusc_scan
  import dusc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       step,
  input  wire logic [7:0] dwell_ticks,
  input  wire cnt_pair_t  cnt,
  output logic      [7:0] digit_enable,
  output logic      [7:0] segments
);

  logic [2:0] pos_r;
  logic [2:0] pos_nxt;
  logic [7:0] dwell_r;
  logic [7:0] dwell_nxt;
  logic [7:0] dwell_inc;
  logic [7:0] limit;
  logic [7:0] pattern;

  // Pick the digit for the current position
  always_comb begin
    case (pos_r)
      POS_A_HUN: pattern = seg_of(cnt.a.hun);
      POS_A_TEN: pattern = seg_of(cnt.a.ten);
      POS_A_UNI: pattern = seg_of(cnt.a.uni);
      POS_SEP_0: pattern = SEP_PATTERN;
      POS_SEP_1: pattern = SEP_PATTERN;
      POS_B_HUN: pattern = seg_of(cnt.b.hun);
      POS_B_TEN: pattern = seg_of(cnt.b.ten);
      POS_B_UNI: pattern = seg_of(cnt.b.uni);
      default:   pattern = SEP_PATTERN;
    endcase
    digit_enable = 8'd1 << pos_r;
    segments     = ~pattern;
  end

  // Advance dwell; a zero setting counts as one
  always_comb begin
    limit     = (dwell_ticks == '0) ? 8'd1 : dwell_ticks;
    dwell_inc = dwell_r + 8'd1;
    if (dwell_inc >= limit || dwell_inc == '0) begin
      dwell_nxt = '0;
      pos_nxt   = pos_r + 3'd1;
    end else begin
      dwell_nxt = dwell_inc;
      pos_nxt   = pos_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= POS_A_HUN;
      dwell_r <= '0;
    end else if (step) begin
      pos_r   <= pos_nxt;
      dwell_r <= dwell_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- sv/dual_updown_counter_seven_seg_scan_core.sv -----
// Top level of the dual up/down counter with eight-digit display scan.
// Depends on dusc_pkg, dusc_counters, dusc_scan and the assertion header.
//
// Usage:
//   Input stream (in_*): one beat per sample of the four button levels.
//     A button acts when it is released. Counters A and B run 0..999.
//   Output stream (out_*): one beat per input beat, carrying the digit
//     enable, active-low segments and both counter values after the sample.
//   Config (cfg_*): dwell_ticks, samples per digit; write only when idle.
// Path: a beat reaches the input register, is processed in one pass
//   and lands in the output register, raising out_tvalid; it moves on
//   from the input register only when the output side is free.
// Throughput: one beat per cycle while out_tready stays high, set by the
//   counter and scan update between the input and output registers.
// Reset: counters go to 984 and 0, scan to digit 0, dwell to 5 samples,
//   both registers empty.
// Stall: while out_tready is low the output beat holds, the input register
//   fills and in_tready drops until the output drains.
`default_nettype none
`include "dual_updown_counter_seven_seg_scan_core_defines.svh"

module dual_updown_counter_seven_seg_scan_core
  import dusc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Config register
  input  wire logic        cfg_wr_en,
  input  wire logic [7:0]  cfg_wr_data,   // dwell_ticks
  // Input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,      // [3:0] buttons, [7:4] zero
  // Output stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata      // [7:0] digit_enable, [15:8] segments,
                                          // [25:16] count_a, [35:26] count_b,
                                          // [39:36] zero
);

  logic        in_vld_r;
  logic [3:0]  in_btn_r;
  logic        out_vld_r;
  logic        out_vld_nxt;
  logic [7:0]  out_de_r;
  logic [7:0]  out_seg_r;
  logic [9:0]  out_ca_r;
  logic [9:0]  out_cb_r;
  logic [7:0]  dwell_r;
  logic        advance;
  cnt_pair_t   cnt_nxt;
  logic [7:0]  digit_enable;
  logic [7:0]  segments;

  // Process the held beat when the output register is free or draining
  assign advance     = in_vld_r & (~out_vld_r | out_tready);
  assign in_tready   = ~in_vld_r | advance;
  assign out_vld_nxt = advance | (out_vld_r & ~out_tready);

  // Config register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dwell_r <= DWELL_RST;
    end else if (cfg_wr_en) begin
      dwell_r <= cfg_wr_data;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_btn_r <= in_tdata[3:0];
    end
  end

  dusc_counters u_counters (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (advance),
    .buttons (in_btn_r),
    .cnt_nxt (cnt_nxt)
  );

  dusc_scan u_scan (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (advance),
    .dwell_ticks  (dwell_r),
    .cnt          (cnt_nxt),
    .digit_enable (digit_enable),
    .segments     (segments)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_de_r  <= digit_enable;
      out_seg_r <= segments;
      out_ca_r  <= cnt_nxt.a.bin;
      out_cb_r  <= cnt_nxt.b.bin;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {4'b0000, out_cb_r, out_ca_r, out_seg_r, out_de_r};

  // Checks
  `DUSC_ASSERT_IMP(a_de_onehot, out_vld_r, $onehot(out_de_r), "digit enable not one-hot")
  `DUSC_ASSERT_IMP(a_point_dark, out_vld_r, out_seg_r[7], "decimal point lit")
  `DUSC_ASSERT_IMP(a_cnt_range, out_vld_r,
    (out_ca_r < 10'(COUNT_MODULUS)) && (out_cb_r < 10'(COUNT_MODULUS)),
    "counter out of range")
  `DUSC_ASSERT_NXT(a_adv_loads, advance, out_vld_r, "processed beat not presented")

endmodule

`default_nettype wire
